FILE: design/mks_pkg.sv
// Shared types, constants and the key table for the matrix keypad scanner.
`default_nettype none

package mks_pkg;

  localparam logic [3:0]  ALL_HIGH       = 4'hF;
  localparam logic [3:0]  ROWS_ALL_LOW   = 4'h0;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd10;
  localparam logic [7:0]  LED_RESET      = 8'hFF;

  // Row, then columns left to right.
  localparam logic [4:0] KEY_TABLE [4][4] = '{
    '{5'd1, 5'd2,  5'd3,  5'd4},
    '{5'd5, 5'd8,  5'd11, 5'd14},
    '{5'd6, 5'd9,  5'd12, 5'd15},
    '{5'd7, 5'd10, 5'd13, 5'd16}
  };

  typedef struct packed {
    logic [3:0] row_drive;
    logic       key_valid;
    logic [4:0] key_code;
    logic [7:0] led_pattern;
  } mks_res_t;

endpackage

`default_nettype wire

FILE: design/mks_ctrl.sv
// Scan sequencer: debounce, row scan, release wait and key decode.
`default_nettype none

module mks_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire logic [3:0]        col_sense,
  input  wire logic [15:0]       debounce_ticks,
  output mks_pkg::mks_res_t      res
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DEBOUNCE,
    PH_SCAN,
    PH_RELEASE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] wait_count_r, wait_count_nxt;
  logic [1:0]  scan_row_r, scan_row_nxt;
  logic [4:0]  held_code_r, held_code_nxt;
  logic [7:0]  led_hold_r, led_hold_nxt;
  logic        col_hit;
  logic [1:0]  col_idx;

  // Exactly one column low gives a usable column.
  always_comb begin
    col_hit = 1'b1;
    col_idx = 2'd0;
    case (col_sense)
      4'h7: col_idx = 2'd0;
      4'hB: col_idx = 2'd1;
      4'hD: col_idx = 2'd2;
      4'hE: col_idx = 2'd3;
      default: col_hit = 1'b0;
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    wait_count_nxt = wait_count_r;
    scan_row_nxt   = scan_row_r;
    held_code_nxt  = held_code_r;
    led_hold_nxt   = led_hold_r;
    res.row_drive  = mks_pkg::ROWS_ALL_LOW;
    res.key_valid  = 1'b0;
    res.key_code   = 5'd0;
    case (phase_r)
      PH_DEBOUNCE: begin
        if (wait_count_r != 16'd0) begin
          wait_count_nxt = wait_count_r - 16'd1;
        end else if (col_sense != mks_pkg::ALL_HIGH) begin
          phase_nxt     = PH_SCAN;
          scan_row_nxt  = 2'd0;
          held_code_nxt = 5'd0;
          res.row_drive = 4'hE;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_SCAN: begin
        // A later matching row overrides an earlier one.
        if (col_hit) begin
          held_code_nxt = mks_pkg::KEY_TABLE[scan_row_r][col_idx];
        end
        if (scan_row_r == 2'd3) begin
          phase_nxt    = PH_RELEASE;
          scan_row_nxt = 2'd0;
        end else begin
          scan_row_nxt  = scan_row_r + 2'd1;
          res.row_drive = ~(4'b0001 << (scan_row_r + 2'd1));
        end
      end
      PH_RELEASE: begin
        if (col_sense == mks_pkg::ALL_HIGH) begin
          res.key_valid = 1'b1;
          res.key_code  = held_code_r;
          led_hold_nxt  = ~{3'b000, held_code_r};
          phase_nxt     = PH_IDLE;
        end
      end
      default: begin
        if (col_sense != mks_pkg::ALL_HIGH) begin
          phase_nxt      = PH_DEBOUNCE;
          wait_count_nxt = debounce_ticks;
        end
      end
    endcase
    res.led_pattern = led_hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      wait_count_r <= 16'd0;
      scan_row_r   <= 2'd0;
      held_code_r  <= 5'd0;
      led_hold_r   <= mks_pkg::LED_RESET;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      wait_count_r <= wait_count_nxt;
      scan_row_r   <= scan_row_nxt;
      held_code_r  <= held_code_nxt;
      led_hold_r   <= led_hold_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/matrix_keypad_scanner.sv
// Top level of the 4x4 matrix keypad scanner.
//
// Input channel (in_valid, in_stall, in_col_sense): one beat per scan tick,
// carrying the active-low column lines sampled under the last row pattern.
// Output channel (out_valid, out_stall, out_*): exactly one beat per input
// beat, in order: the row pattern to drive next tick, a key event flag with
// its code (1..16, or 0 when no single key matched), and the held LED value.
// Config channel (cfg_valid, cfg_ready, cfg_data): writes debounce_ticks;
// always ready, write it only while the scanner is idle.
// An input beat goes from the input register through the sequencer into the
// output register. Throughput is one beat per cycle while out_stall is low;
// the sequencer state update sets it.
// A stall on the output holds the output register; the input register keeps
// taking a beat while the output slot is free or draining, so in_stall rises
// only when both registers are full and out_stall is high.
// Reset (synchronous, active low) empties both registers, puts the sequencer
// in idle, sets debounce_ticks to 10 and the LED pattern to all ones.
`default_nettype none

module matrix_keypad_scanner (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [3:0]  in_col_sense,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [3:0]  out_row_drive,
  output      logic        out_key_valid,
  output      logic [4:0]  out_key_code,
  output      logic [7:0]  out_led_pattern,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic              in_vld_r;
  logic [3:0]        in_col_r;
  logic              out_vld_r;
  mks_pkg::mks_res_t out_res_r;
  mks_pkg::mks_res_t step_res;
  logic [15:0]       debounce_r;
  logic              out_free;
  logic              step_en;
  logic              in_take;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_vld_r || !out_stall;
  assign step_en   = in_vld_r && out_free;
  assign in_stall  = in_vld_r && !out_free;
  assign in_take   = in_valid && !in_stall;

  mks_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (step_en),
    .col_sense      (in_col_r),
    .debounce_ticks (debounce_r),
    .res            (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= mks_pkg::DEBOUNCE_RESET;
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        debounce_r <= cfg_data;
      end
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (out_free) begin
        in_vld_r <= 1'b0;
      end
      // Advance the output slot when it is free; hold it under stall.
      if (out_free) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_col_r <= in_col_sense;
    end
    if (step_en) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_row_drive   = out_res_r.row_drive;
  assign out_key_valid   = out_res_r.key_valid;
  assign out_key_code    = out_res_r.key_code;
  assign out_led_pattern = out_res_r.led_pattern;

endmodule

`default_nettype wire

FILE: dv/mks_checker.sv
// Checker for the keypad scanner: predicts every output beat and compares it.
`timescale 1ns / 1ps

module mks_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [3:0]  in_col_sense,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_row_drive,
  input  logic        out_key_valid,
  input  logic [4:0]  out_key_code,
  input  logic [7:0]  out_led_pattern,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  typedef enum logic [1:0] {PH_IDLE, PH_DEBOUNCE, PH_SCAN, PH_RELEASE} scan_phase_t;

  scan_phase_t       phase;
  logic [15:0]       debounce_ticks;
  logic [15:0]       wait_count;
  logic [1:0]        scan_row;
  logic [4:0]        held_code;
  logic [7:0]        led_hold;
  mks_pkg::mks_res_t results_due[$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  // Column index when exactly one line is low, else -1.
  function automatic int low_column(input logic [3:0] cols);
    case (cols)
      4'h7:    return 0;
      4'hB:    return 1;
      4'hD:    return 2;
      4'hE:    return 3;
      default: return -1;
    endcase
  endfunction

  function automatic logic [3:0] row_select(input logic [1:0] row);
    return ~(4'b0001 << row);
  endfunction

  task automatic scan_tick(input logic [3:0] cols, output mks_pkg::mks_res_t res);
    int col;
    res = '0;
    res.row_drive = mks_pkg::ROWS_ALL_LOW;
    case (phase)
      PH_DEBOUNCE: begin
        if (wait_count != 16'd0) begin
          wait_count = wait_count - 16'd1;
        end else if (cols != mks_pkg::ALL_HIGH) begin
          phase = PH_SCAN;
          scan_row = 2'd0;
          held_code = 5'd0;
          res.row_drive = row_select(2'd0);
        end else begin
          phase = PH_IDLE;
        end
      end
      PH_SCAN: begin
        col = low_column(cols);
        // later rows overwrite an earlier match
        if (col >= 0) held_code = mks_pkg::KEY_TABLE[scan_row][col[1:0]];
        if (scan_row == 2'd3) begin
          phase = PH_RELEASE;
          scan_row = 2'd0;
        end else begin
          scan_row = scan_row + 2'd1;
          res.row_drive = row_select(scan_row);
        end
      end
      PH_RELEASE: begin
        if (cols == mks_pkg::ALL_HIGH) begin
          res.key_valid = 1'b1;
          res.key_code = held_code;
          led_hold = ~{3'b000, held_code};
          phase = PH_IDLE;
        end
      end
      default: begin
        if (cols != mks_pkg::ALL_HIGH) begin
          phase = PH_DEBOUNCE;
          wait_count = debounce_ticks;
        end
      end
    endcase
    res.led_pattern = led_hold;
  endtask

  task automatic flag(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    mks_pkg::mks_res_t want;
    mks_pkg::mks_res_t got;
    if (!rst_n) begin
      phase = PH_IDLE;
      debounce_ticks = mks_pkg::DEBOUNCE_RESET;
      wait_count = 16'd0;
      scan_row = 2'd0;
      held_code = 5'd0;
      led_hold = mks_pkg::LED_RESET;
      results_due.delete();
    end else begin
      // check the outgoing beat before predicting a new one
      if (out_valid && !out_stall) begin
        got.row_drive = out_row_drive;
        got.key_valid = out_key_valid;
        got.key_code = out_key_code;
        got.led_pattern = out_led_pattern;
        if (results_due.size() == 0) begin
          flag($sformatf("output beat with nothing expected: row=%h valid=%b code=%0d led=%h",
                         got.row_drive, got.key_valid, got.key_code, got.led_pattern));
        end else begin
          want = results_due.pop_front();
          if (got.row_drive !== want.row_drive || got.key_valid !== want.key_valid ||
              got.key_code !== want.key_code || got.led_pattern !== want.led_pattern) begin
            flag($sformatf({"expected row=%h valid=%b code=%0d led=%h, ",
                            "got row=%h valid=%b code=%0d led=%h"},
                           want.row_drive, want.key_valid, want.key_code, want.led_pattern,
                           got.row_drive, got.key_valid, got.key_code, got.led_pattern));
          end
        end
      end
      if (cfg_valid && cfg_ready) debounce_ticks = cfg_data;
      if (in_valid && !in_stall) begin
        scan_tick(in_col_sense, want);
        results_due.push_back(want);
      end
    end
    pending = results_due.size();
  end

endmodule

FILE: dv/tb_matrix_keypad_scanner.sv
// Testbench top: drives column beats, output backpressure and debounce writes.
`timescale 1ns / 1ps

module tb_matrix_keypad_scanner;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_BEATS  = 1560;
  localparam int LONG_DEBOUNCE = 40;

  // zero debounce throughout: clean press, bounce, multi-column and override, no match
  localparam logic [3:0] DIRECTED_COLS [26] = '{
    4'hF, 4'hF,
    4'hE, 4'hE, 4'hF, 4'hF, 4'hF, 4'hE, 4'hF,
    4'h0, 4'hF,
    4'h3, 4'h3, 4'h3, 4'hB, 4'h0, 4'hD, 4'h5, 4'hF,
    4'hA, 4'hA, 4'hF, 4'hF, 4'h9, 4'hF, 4'hF
  };
  localparam int PHASE_DEBOUNCE [5] = '{3, 1, 10, 0, 2};
  localparam int IDLE_PCT [4]       = '{0, 56, 0, 34};
  localparam int STALL_PCT [4]      = '{0, 0, 56, 34};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_col_sense = mks_pkg::ALL_HIGH;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_row_drive;
  logic        out_key_valid;
  logic [4:0]  out_key_code;
  logic [7:0]  out_led_pattern;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int mismatches;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int beats_sent = 0;
  int cur_debounce = mks_pkg::DEBOUNCE_RESET;
  int cycle_count = 0;

  always #4 clk = ~clk;

  matrix_keypad_scanner uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_col_sense   (in_col_sense),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row_drive  (out_row_drive),
    .out_key_valid  (out_key_valid),
    .out_key_code   (out_key_code),
    .out_led_pattern(out_led_pattern),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  mks_checker key_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_col_sense   (in_col_sense),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row_drive  (out_row_drive),
    .out_key_valid  (out_key_valid),
    .out_key_code   (out_key_code),
    .out_led_pattern(out_led_pattern),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  // Any pattern with at least one column low.
  function automatic logic [3:0] held_cols();
    return 4'($urandom_range(14));
  endfunction

  task automatic send_beat(input logic [3:0] cols);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_col_sense <= cols;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // Drop valid, wait for every predicted beat, then let the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_debounce(input int ticks);
    cfg_valid <= 1'b1;
    cfg_data <= 16'(ticks);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur_debounce = ticks;
  endtask

  // One press from idle: detect, debounce, recheck, four row scans, release; some presses end at the recheck.
  task automatic press_sequence();
    int lead;
    int pick;
    lead = $urandom_range(3);
    repeat (lead) send_beat(mks_pkg::ALL_HIGH);
    send_beat(held_cols());
    repeat (cur_debounce) send_beat(4'($urandom));
    if ($urandom_range(9) == 0) begin
      send_beat(mks_pkg::ALL_HIGH);
    end else begin
      send_beat(held_cols());
      repeat (4) begin
        pick = $urandom_range(9);
        if (pick < 6) send_beat(~(4'b1000 >> $urandom_range(3)));
        else if (pick < 8) send_beat(mks_pkg::ALL_HIGH);
        else send_beat(4'($urandom));
      end
      lead = $urandom_range(3);
      repeat (lead) send_beat(held_cols());
      send_beat(mks_pkg::ALL_HIGH);
    end
  endtask

  // Output side: random stall, or a long hold-off when one is requested.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
        @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** matrix_keypad_scanner: FAILED **");
    $finish;
  end

  initial begin
    int phase_end;
    int mode;
    int burst;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_debounce(0);
    foreach (DIRECTED_COLS[i]) send_beat(DIRECTED_COLS[i]);
    settle();

    // long debounce, rewritten while the wait runs
    write_debounce(LONG_DEBOUNCE);
    send_beat(4'h7);
    repeat (20) send_beat(4'($urandom));
    settle();
    write_debounce(3);
    repeat (LONG_DEBOUNCE - 20) send_beat(4'($urandom));
    send_beat(4'h7);
    send_beat(4'h7);
    repeat (4) send_beat(mks_pkg::ALL_HIGH);
    press_sequence();
    settle();

    for (int p = 0; p < 5; p++) begin
      write_debounce(PHASE_DEBOUNCE[p]);
      mode = (p < 4) ? p : 0;
      idle_pct = IDLE_PCT[mode];
      stall_pct = STALL_PCT[mode];
      // hold the output off while beats keep coming, so the input backs up
      if (p == 2) hold_cycles = 300;
      phase_end = beats_sent + RANDOM_BEATS / 5;
      while (beats_sent < phase_end) begin
        if (p == 4) begin
          mode = $urandom_range(3);
          idle_pct = IDLE_PCT[mode];
          stall_pct = STALL_PCT[mode];
        end
        if ($urandom_range(9) == 0) begin
          burst = $urandom_range(1, 6);
          repeat (burst) send_beat(4'($urandom));
          repeat (cur_debounce + 6) send_beat(mks_pkg::ALL_HIGH);
        end else begin
          press_sequence();
        end
      end
      settle();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("** matrix_keypad_scanner: PASSED **");
    end else begin
      $display("** matrix_keypad_scanner: FAILED **");
    end
    $finish;
  end

endmodule
